/* design/cbh_pkg.sv */
// Shared types and constants of the centered-bin histogram.
// Holds the word formats of both channels, register indexes and datapath widths.
// No dependencies.
package cbh_pkg;

  // Fixed widths of the payload fields.
  localparam int CountBits  = 24;
  localparam int IntenBits  = 8;
  localparam int SelBits    = 6;
  localparam int CfgBits    = 8;
  localparam int CfgIdxBits = 2;

  // Default number of bins.
  localparam int NbinsDef = 64;

  // Width of the divider datapath; holds doubled intensities plus one bin width.
  localparam int DivW = 10;

  localparam logic [CountBits-1:0] CountMax = '1;

  // Operation codes.
  localparam logic OpCount = 1'b0;
  localparam logic OpRead  = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] RegFirstCentre    = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegBinWidth       = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegLastCentreLimit = 2'd2;

  typedef struct packed {
    logic                 operation;
    logic [IntenBits-1:0] intensity;
    logic [SelBits-1:0]   bin_select;
  } cbh_in_t;

  typedef struct packed {
    logic [CountBits-1:0] count;
    logic                 bin_in_use;
  } cbh_out_t;

endpackage

/* design/cbh_divider.sv */
// Restoring divider that produces one quotient bit per cycle.
// Takes nothing from cbh_pkg and follows only the house conventions; standalone.
// A start pulse loads the operands; done_o pulses once the quotient is final.
module cbh_divider #(
  parameter int W = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic [W-1:0] quotient_o,
  output logic         done_o
);

  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, quo_q, div_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [W:0]      trial;
  logic            fits;
  logic [W-1:0]    rem_d;

  assign trial = {rem_q, quo_q[W-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign rem_d = fits ? W'(trial - {1'b0, div_q}) : trial[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      div_q  <= divisor_i;
      cnt_q  <= CntW'(W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      rem_q  <= rem_d;
      quo_q  <= {quo_q[W-2:0], fits};
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

/* design/cbh_count_mem.sv */
// Bin count store: one write port, one read port, registered read data.
// Per-entry valid bits make every entry read as zero until first written.
// Standalone; the top level sizes it from its bin count.
module cbh_count_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [DW-1:0]    rd_data_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* design/centered_bin_histogram.sv */
// Top level of the centered-bin intensity histogram.
// Depends on cbh_pkg, cbh_divider and cbh_count_mem.
//
// Usage:
//   Input words arrive on item_i and are taken at a rising edge with start
//   high and busy low. A count word adds one (saturating) to the bin of its
//   intensity and gives no result. A read word returns the selected bin's
//   count and in-use flag and clears that bin.
//   The result word sits on result_o for exactly one cycle, marked by
//   result_valid_o; the receiver cannot stall it.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while busy is low; writes take effect at once and need no handshake.
//   Busy stays high from acceptance until the word is done: the two
//   bit-serial divisions find the bin index and the number of bins in
//   use, then the count store is read and the new count written back.
//   A read result appears in the first cycle that busy is low again, and
//   a new word is taken only once the previous one is finished.
//   Reset clears the registers to their defaults and marks every bin count
//   as zero at once; the block accepts words in the first cycle after reset.
module centered_bin_histogram
  import cbh_pkg::*;
#(
  parameter int NBINS = NbinsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cbh_in_t               item_i,
  output logic                  result_valid_o,
  output cbh_out_t              result_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_wdata_i
);

  localparam int IdxW = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam logic [DivW-1:0] LastBin = DivW'(NBINS - 1);
  localparam logic [DivW-1:0] NbinsW  = DivW'(NBINS);

  typedef enum logic [1:0] {StIdle, StDiv, StRd} state_e;

  state_e state_q;

  logic [CfgBits-1:0] first_centre_q, bin_width_q, last_limit_q;

  // Word latched at acceptance.
  logic               op_q;
  logic [SelBits-1:0] sel_q;
  logic               below_q, end_below_q;

  logic [IdxW-1:0]    addr_q;
  logic               in_use_q, sel_ok_q;
  logic               result_valid_q;
  cbh_out_t           result_q;

  logic accept;
  assign accept = start && (state_q == StIdle);
  assign busy   = (state_q != StIdle);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_centre_q <= 8'd0;
      bin_width_q    <= 8'd4;
      last_limit_q   <= 8'd252;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFirstCentre:     first_centre_q <= cfg_wdata_i;
        RegBinWidth:        bin_width_q    <= cfg_wdata_i;
        RegLastCentreLimit: last_limit_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Divider operands; those for the bin index are at doubled (half-unit) resolution.
  logic [CfgBits-1:0] w_eff;
  logic [DivW-1:0]    x2, e0, w2, k_dividend, m_dividend;
  logic               below, end_below;

  assign w_eff      = (bin_width_q == '0) ? CfgBits'(1) : bin_width_q;
  assign x2         = {1'b0, item_i.intensity, 1'b0};
  assign e0         = DivW'({first_centre_q, 1'b0}) + DivW'(w_eff);
  assign w2         = DivW'({w_eff, 1'b0});
  assign below      = x2 <= e0;
  assign k_dividend = below ? '0 : DivW'(x2 - e0 + w2 - DivW'(1));
  assign end_below  = last_limit_q < first_centre_q;
  assign m_dividend = end_below ? '0 : DivW'(last_limit_q - first_centre_q);

  logic [DivW-1:0] qk, qm;
  logic            k_done, m_done;

  cbh_divider #(.W(DivW)) u_div_bin (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (k_dividend),
    .divisor_i  (w2),
    .quotient_o (qk),
    .done_o     (k_done)
  );

  cbh_divider #(.W(DivW)) u_div_used (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (m_dividend),
    .divisor_i  (DivW'(w_eff)),
    .quotient_o (qm),
    .done_o     (m_done)
  );

  // Last bin in use, bin index and read address once both quotients are final.
  logic [DivW-1:0] last_used, kbin, sel_ext, addr_full;
  logic            sel_ok, in_use, div_done;

  assign div_done  = (state_q == StDiv) && k_done && m_done;
  assign last_used = end_below_q ? '0 : ((qm > LastBin) ? LastBin : qm);
  assign kbin      = below_q ? '0 : ((qk > last_used) ? last_used : qk);
  assign sel_ext   = DivW'(sel_q);
  assign sel_ok    = sel_ext < NbinsW;
  assign in_use    = sel_ext <= last_used;
  assign addr_full = (op_q == OpRead) ? sel_ext : kbin;

  logic                 rd_en, wr_en;
  logic [CountBits-1:0] rd_data, wr_data;

  assign rd_en   = div_done && ((op_q == OpCount) || sel_ok);
  assign wr_en   = (state_q == StRd) && ((op_q == OpCount) || sel_ok_q);
  assign wr_data = (op_q == OpRead) ? '0
                 : ((rd_data == CountMax) ? rd_data : rd_data + 1'b1);

  cbh_count_mem #(
    .DEPTH (NBINS),
    .AW    (IdxW),
    .DW    (CountBits)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_full[IdxW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (wr_data)
  );

  // Sequencer with the registered result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      op_q           <= OpCount;
      sel_q          <= '0;
      below_q        <= 1'b0;
      end_below_q    <= 1'b0;
      addr_q         <= '0;
      in_use_q       <= 1'b0;
      sel_ok_q       <= 1'b0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start) begin
            op_q        <= item_i.operation;
            sel_q       <= item_i.bin_select;
            below_q     <= below;
            end_below_q <= end_below;
            state_q     <= StDiv;
          end
        end
        StDiv: begin
          if (div_done) begin
            addr_q   <= addr_full[IdxW-1:0];
            in_use_q <= in_use;
            sel_ok_q <= sel_ok;
            state_q  <= StRd;
          end
        end
        StRd: begin
          if (op_q == OpRead) begin
            result_valid_q      <= 1'b1;
            result_q.count      <= sel_ok_q ? rd_data : '0;
            result_q.bin_in_use <= in_use_q && sel_ok_q;
          end
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted word did not raise busy");

  a_done_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_done == m_done)
    else $error("dividers finished out of step");

  a_write_in_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> $past(state_q == StDiv) && $past(div_done))
    else $error("count store written outside read-modify-write");

  a_result_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == StRd) && $past(op_q == OpRead) && !busy)
    else $error("result word without a read word");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (op_q == OpCount)) |-> (wr_data != '0))
    else $error("counting wrote a zero count");

endmodule
